@@ hw/rtl/gic_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_pkg
// Shared types, register indexes and the CORDIC arctangent table of the
// gamepad input conditioner.
// ----------------------------------------------------------------------------
package gic_pkg;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_STICK_DZ   = 2'd0;
	localparam logic [1:0] REG_TRIGGER_DZ = 2'd1;
	localparam logic [1:0] REG_SOURCE     = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [14:0] STICK_DZ_RESET   = 15'd7209;
	localparam logic [14:0] TRIGGER_DZ_RESET = 15'd4915;

	// Shared divider geometry.
	localparam int DIV_N_W = 48;
	localparam int DIV_D_W = 32;

	// Number of vectoring CORDIC steps.
	localparam int CORD_STEPS = 20;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLAMP,
		OP_SQX,
		OP_SQY,
		OP_SQRT_STEP,
		OP_CHECK,
		OP_DIVQ_LD,
		OP_QSTORE,
		OP_MULX,
		OP_MULY,
		OP_DIVD_LD,
		OP_DIRX_ST,
		OP_DIRY_ST,
		OP_CORD_INIT,
		OP_CORD_STEP,
		OP_ANG_ST,
		OP_TRG_LD,
		OP_TRG_ST,
		OP_PUBLISH
	} gic_op_t;

	typedef struct packed {
		gic_op_t op;
		logic    side;
	} gic_cmd_t;

	typedef struct packed {
		logic pad;
		logic zero;
		logic sqrt_last;
		logic cord_last;
		logic div_done;
	} gic_status_t;

	// Arctangent of 2^-i as a fraction of a full turn, 2^32 per turn.
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

@@ hw/rtl/gic_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gic_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [gic_pkg::DIV_N_W-1:0]  dividend,
	input  logic [gic_pkg::DIV_D_W-1:0]  divisor,
	output logic [gic_pkg::DIV_N_W-1:0]  quot,
	output logic                         done
);

	localparam int CNT_W = $clog2(gic_pkg::DIV_N_W + 1);

	logic [gic_pkg::DIV_D_W-1:0] rem_q;
	logic [gic_pkg::DIV_D_W-1:0] den_q;
	logic [gic_pkg::DIV_N_W-1:0] quo_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [gic_pkg::DIV_D_W:0]   trial;
	logic                        fits;

	// Shift in the next dividend bit and try the subtraction.
	assign trial = {rem_q, quo_q[gic_pkg::DIV_N_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(gic_pkg::DIV_N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? gic_pkg::DIV_D_W'(trial - {1'b0, den_q})
			              : trial[gic_pkg::DIV_D_W-1:0];
			quo_q <= {quo_q[gic_pkg::DIV_N_W-2:0], fits};
		end
	end

	assign quot = quo_q;
	assign done = done_q;

	done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider reports done while still iterating");

	start_reload: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (busy_q && cnt_q == CNT_W'(gic_pkg::DIV_N_W)))
		else $error("divider did not load its step count");

	finish_count: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> (done_q && cnt_q == '0))
		else $error("divider stopped before the last step");

endmodule

@@ hw/rtl/gic_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_datapath
// Sample registers, square root, deadzone arithmetic, shared divider,
// CORDIC and the result registers of the gamepad input conditioner.
// ----------------------------------------------------------------------------
module gic_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  gic_pkg::gic_cmd_t   cmd,
	output gic_pkg::gic_status_t status,
	input  logic [14:0]         stick_dz,
	input  logic [14:0]         trigger_dz,
	input  logic                mode,
	input  logic signed [15:0]  left_x_raw,
	input  logic signed [15:0]  left_y_raw,
	input  logic signed [15:0]  right_x_raw,
	input  logic signed [15:0]  right_y_raw,
	input  logic [14:0]         left_trigger_raw,
	input  logic [14:0]         right_trigger_raw,
	input  logic [14:0]         button_mask,
	input  logic                pad_present,
	output logic signed [15:0]  left_dir_x,
	output logic signed [15:0]  left_dir_y,
	output logic [15:0]         left_magnitude,
	output logic signed [15:0]  left_angle,
	output logic signed [15:0]  right_dir_x,
	output logic signed [15:0]  right_dir_y,
	output logic [15:0]         right_magnitude,
	output logic signed [15:0]  right_angle,
	output logic [15:0]         left_trigger_level,
	output logic [15:0]         right_trigger_level,
	output logic [14:0]         pressed_edges,
	output logic [14:0]         released_edges
);

	localparam int IDX_W = $clog2(gic_pkg::CORD_STEPS);

	// Captured sample.
	logic signed [15:0] lx_q, ly_q, rx_q, ry_q;
	logic [14:0]        lt_q, rt_q;
	logic [14:0]        cur_q;
	logic [14:0]        prev_q;
	logic               pad_q;

	// Working registers.
	logic signed [15:0] nx_q, ny_q;
	logic [30:0]        s_q;
	logic [61:0]        rem_q, r_q, b_q;
	logic               zero_q;
	logic [15:0]        q_q;
	logic [30:0]        prod_q;
	logic signed [35:0] cx_q, cy_q;
	logic [31:0]        cz_q;
	logic [IDX_W-1:0]   ci_q;

	// Staged results, one entry per side.
	logic signed [15:0] res_dx_q [2];
	logic signed [15:0] res_dy_q [2];
	logic [15:0]        res_mag_q [2];
	logic signed [15:0] res_ang_q [2];
	logic [15:0]        res_tr_q [2];

	// Divider interface.
	logic                        div_start;
	logic [gic_pkg::DIV_N_W-1:0] div_num;
	logic [gic_pkg::DIV_D_W-1:0] div_den;
	logic [gic_pkg::DIV_N_W-1:0] div_quot;
	logic                        div_done;

	// Clamp a widened axis value to plus or minus full scale.
	function automatic logic signed [15:0] clamp_axis(input logic signed [16:0] v);
		logic signed [15:0] o;
		if (v > 17'sd32767) begin
			o = 16'sd32767;
		end else if (v < -17'sd32767) begin
			o = -16'sd32767;
		end else begin
			o = v[15:0];
		end
		return o;
	endfunction

	// Side selection and axis clamp, Y negated in the alternate mode.
	logic signed [15:0] sel_x, sel_y;
	logic signed [16:0] wide_y;
	logic [14:0]        ax, ay;

	assign sel_x  = cmd.side ? rx_q : lx_q;
	assign sel_y  = cmd.side ? ry_q : ly_q;
	assign wide_y = mode ? -{sel_y[15], sel_y} : {sel_y[15], sel_y};
	assign ax     = nx_q[15] ? 15'(-nx_q) : nx_q[14:0];
	assign ay     = ny_q[15] ? 15'(-ny_q) : ny_q[14:0];

	// Square root step.
	logic [61:0] rb;
	assign rb = r_q + b_q;

	// Deadzone threshold and rescale divisor for the sticks.
	logic [29:0] k_stick;
	logic [15:0] dzc;
	logic [30:0] den_stick;
	logic [30:0] r_minus_k;

	assign k_stick   = {stick_dz, 15'd0} - {15'd0, stick_dz};
	assign dzc       = 16'h8000 - {1'b0, stick_dz};
	assign den_stick = {dzc, 15'd0} - {15'd0, dzc};
	assign r_minus_k = r_q[30:0] - {1'b0, k_stick};

	// Trigger deadzone terms.
	logic [14:0] trg_raw, trg_full, trg_clamp;
	logic [29:0] trg_a, trg_b;
	logic [15:0] tzc;
	logic [30:0] trg_den;
	logic [29:0] trg_diff;

	assign trg_raw   = cmd.side ? rt_q : lt_q;
	assign trg_full  = mode ? 15'd255 : 15'd32767;
	assign trg_clamp = (trg_raw > trg_full) ? trg_full : trg_raw;
	assign trg_a     = {trg_clamp, 15'd0};
	assign trg_b     = mode ? {7'd0, {trigger_dz, 8'd0} - {8'd0, trigger_dz}}
	                        : {trigger_dz, 15'd0} - {15'd0, trigger_dz};
	assign tzc       = 16'h8000 - {1'b0, trigger_dz};
	assign trg_den   = mode ? {7'd0, {tzc, 8'd0} - {8'd0, tzc}}
	                        : {tzc, 15'd0} - {15'd0, tzc};
	assign trg_diff  = trg_a - trg_b;

	// CORDIC step terms.
	logic signed [35:0] cdx, cdy;
	logic signed [35:0] cx0, cy0;

	assign cdx = cy_q >>> ci_q;
	assign cdy = cx_q >>> ci_q;
	assign cx0 = {{4{nx_q[15]}}, nx_q, 16'd0};
	assign cy0 = {{4{ny_q[15]}}, ny_q, 16'd0};

	// Saturated quotient forms.
	logic [15:0] quot_q1;
	logic [14:0] quot_dir;
	logic [15:0] dir_val;
	logic        dir_neg;
	logic [31:0] z_round;

	assign quot_q1  = (div_quot > 48'd32768) ? 16'h8000 : div_quot[15:0];
	assign quot_dir = (div_quot > 48'd32767) ? 15'h7fff : div_quot[14:0];
	assign dir_neg  = (cmd.op == gic_pkg::OP_DIRX_ST) ? nx_q[15] : ny_q[15];
	assign dir_val  = dir_neg ? 16'(-{1'b0, quot_dir}) : {1'b0, quot_dir};
	assign z_round  = cz_q + 32'h8000;

	// Divider operands by operation.
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (cmd.op)
			gic_pkg::OP_DIVQ_LD: begin
				div_start = 1'b1;
				div_num   = {2'd0, r_minus_k, 15'd0} + {18'd0, den_stick[30:1]};
				div_den   = {1'b0, den_stick};
			end
			gic_pkg::OP_DIVD_LD: begin
				div_start = 1'b1;
				div_num   = {2'd0, prod_q, 15'd0} + {18'd0, r_q[30:1]};
				div_den   = {1'b0, r_q[30:0]};
			end
			gic_pkg::OP_TRG_LD: begin
				div_start = 1'b1;
				div_num   = {3'd0, trg_diff, 15'd0} + {18'd0, trg_den[30:1]};
				div_den   = {1'b0, trg_den};
			end
			default: begin
			end
		endcase
	end

	gic_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quot     (div_quot),
		.done     (div_done)
	);

	// Previous button mask.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (cmd.op == gic_pkg::OP_PUBLISH) begin
			prev_q <= cur_q;
		end
	end

	// Working and result registers.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			gic_pkg::OP_LOAD: begin
				lx_q  <= left_x_raw;
				ly_q  <= left_y_raw;
				rx_q  <= right_x_raw;
				ry_q  <= right_y_raw;
				lt_q  <= left_trigger_raw;
				rt_q  <= right_trigger_raw;
				pad_q <= pad_present;
				cur_q <= pad_present ? button_mask : 15'd0;
				for (int i = 0; i < 2; i++) begin
					res_dx_q[i]  <= '0;
					res_dy_q[i]  <= '0;
					res_mag_q[i] <= '0;
					res_ang_q[i] <= '0;
					res_tr_q[i]  <= '0;
				end
			end
			gic_pkg::OP_CLAMP: begin
				nx_q <= clamp_axis({sel_x[15], sel_x});
				ny_q <= clamp_axis(wide_y);
			end
			gic_pkg::OP_SQX: begin
				s_q <= 31'(ax) * 31'(ax);
			end
			gic_pkg::OP_SQY: begin
				s_q   <= s_q + 31'(ay) * 31'(ay);
				rem_q <= {1'b0, s_q + 31'(ay) * 31'(ay), 30'd0};
				r_q   <= '0;
				b_q   <= 62'd1 << 60;
			end
			gic_pkg::OP_SQRT_STEP: begin
				if (rem_q >= rb) begin
					rem_q <= rem_q - rb;
					r_q   <= (r_q >> 1) + b_q;
				end else begin
					r_q <= r_q >> 1;
				end
				b_q <= b_q >> 2;
			end
			gic_pkg::OP_CHECK: begin
				zero_q <= (s_q == '0) || (r_q < {32'd0, k_stick});
			end
			gic_pkg::OP_QSTORE: begin
				q_q                 <= quot_q1;
				res_mag_q[cmd.side] <= quot_q1;
			end
			gic_pkg::OP_MULX: begin
				prod_q <= ax * q_q;
			end
			gic_pkg::OP_MULY: begin
				prod_q <= ay * q_q;
			end
			gic_pkg::OP_DIRX_ST: begin
				res_dx_q[cmd.side] <= dir_val;
			end
			gic_pkg::OP_DIRY_ST: begin
				res_dy_q[cmd.side] <= dir_val;
			end
			gic_pkg::OP_CORD_INIT: begin
				ci_q <= '0;
				if (nx_q[15]) begin
					cx_q <= -cx0;
					cy_q <= -cy0;
					cz_q <= 32'h8000_0000;
				end else begin
					cx_q <= cx0;
					cy_q <= cy0;
					cz_q <= '0;
				end
			end
			gic_pkg::OP_CORD_STEP: begin
				if (!cy_q[35]) begin
					cx_q <= cx_q + cdx;
					cy_q <= cy_q - cdy;
					cz_q <= cz_q + gic_pkg::atan_turn(5'(ci_q));
				end else begin
					cx_q <= cx_q - cdx;
					cy_q <= cy_q + cdy;
					cz_q <= cz_q - gic_pkg::atan_turn(5'(ci_q));
				end
				ci_q <= ci_q + 1'b1;
			end
			gic_pkg::OP_ANG_ST: begin
				res_ang_q[cmd.side] <= z_round[31:16];
			end
			gic_pkg::OP_TRG_LD: begin
				zero_q <= trg_a < trg_b;
			end
			gic_pkg::OP_TRG_ST: begin
				res_tr_q[cmd.side] <= zero_q ? 16'd0 : quot_q1;
			end
			gic_pkg::OP_PUBLISH: begin
				left_dir_x          <= res_dx_q[0];
				left_dir_y          <= res_dy_q[0];
				left_magnitude      <= res_mag_q[0];
				left_angle          <= res_ang_q[0];
				right_dir_x         <= res_dx_q[1];
				right_dir_y         <= res_dy_q[1];
				right_magnitude     <= res_mag_q[1];
				right_angle         <= res_ang_q[1];
				left_trigger_level  <= res_tr_q[0];
				right_trigger_level <= res_tr_q[1];
				pressed_edges       <= cur_q & ~prev_q;
				released_edges      <= prev_q & ~cur_q;
			end
			default: begin
			end
		endcase
	end

	// Status back to the controller.
	assign status.pad       = pad_q;
	assign status.zero      = zero_q;
	assign status.sqrt_last = b_q[0];
	assign status.cord_last = ci_q == IDX_W'(gic_pkg::CORD_STEPS - 1);
	assign status.div_done  = div_done;

endmodule

@@ hw/rtl/gic_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_ctrl
// Sequencer of the gamepad input conditioner: steps the datapath through both
// sticks and both triggers when the pad is present and owns the handshakes.
// ----------------------------------------------------------------------------
module gic_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  gic_pkg::gic_status_t status,
	output gic_pkg::gic_cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ROUTE,
		ST_CLAMP,
		ST_SQX,
		ST_SQY,
		ST_SQRT,
		ST_CHECK,
		ST_BRANCH,
		ST_DIVQ_LD,
		ST_DIVQ_W,
		ST_QSTORE,
		ST_MULX,
		ST_DIVX_LD,
		ST_DIVX_W,
		ST_DIRX_ST,
		ST_MULY,
		ST_DIVY_LD,
		ST_DIVY_W,
		ST_DIRY_ST,
		ST_CORD_INIT,
		ST_CORD,
		ST_ANG_ST,
		ST_TRG_LD,
		ST_TRG_W,
		ST_TRG_ST,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   side_q;
	logic   out_valid_q;
	logic   publish;

	assign publish = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	// Operation decode from the current state.
	always_comb begin
		cmd.side = side_q;
		unique case (state_q)
			ST_IDLE:      cmd.op = in_valid ? gic_pkg::OP_LOAD : gic_pkg::OP_NONE;
			ST_CLAMP:     cmd.op = gic_pkg::OP_CLAMP;
			ST_SQX:       cmd.op = gic_pkg::OP_SQX;
			ST_SQY:       cmd.op = gic_pkg::OP_SQY;
			ST_SQRT:      cmd.op = gic_pkg::OP_SQRT_STEP;
			ST_CHECK:     cmd.op = gic_pkg::OP_CHECK;
			ST_DIVQ_LD:   cmd.op = gic_pkg::OP_DIVQ_LD;
			ST_QSTORE:    cmd.op = gic_pkg::OP_QSTORE;
			ST_MULX:      cmd.op = gic_pkg::OP_MULX;
			ST_DIVX_LD:   cmd.op = gic_pkg::OP_DIVD_LD;
			ST_DIRX_ST:   cmd.op = gic_pkg::OP_DIRX_ST;
			ST_MULY:      cmd.op = gic_pkg::OP_MULY;
			ST_DIVY_LD:   cmd.op = gic_pkg::OP_DIVD_LD;
			ST_DIRY_ST:   cmd.op = gic_pkg::OP_DIRY_ST;
			ST_CORD_INIT: cmd.op = gic_pkg::OP_CORD_INIT;
			ST_CORD:      cmd.op = gic_pkg::OP_CORD_STEP;
			ST_ANG_ST:    cmd.op = gic_pkg::OP_ANG_ST;
			ST_TRG_LD:    cmd.op = gic_pkg::OP_TRG_LD;
			ST_TRG_ST:    cmd.op = gic_pkg::OP_TRG_ST;
			ST_OUT:       cmd.op = publish ? gic_pkg::OP_PUBLISH : gic_pkg::OP_NONE;
			default:      cmd.op = gic_pkg::OP_NONE;
		endcase
	end

	// State, side and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			side_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					side_q <= 1'b0;
					if (in_valid) begin
						state_q <= ST_ROUTE;
					end
				end
				ST_ROUTE:   state_q <= status.pad ? ST_CLAMP : ST_OUT;
				ST_CLAMP:   state_q <= ST_SQX;
				ST_SQX:     state_q <= ST_SQY;
				ST_SQY:     state_q <= ST_SQRT;
				ST_SQRT: begin
					if (status.sqrt_last) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK:   state_q <= ST_BRANCH;
				ST_BRANCH: begin
					// A stick inside the deadzone keeps its cleared results.
					if (!status.zero) begin
						state_q <= ST_DIVQ_LD;
					end else if (side_q) begin
						side_q  <= 1'b0;
						state_q <= ST_TRG_LD;
					end else begin
						side_q  <= 1'b1;
						state_q <= ST_CLAMP;
					end
				end
				ST_DIVQ_LD: state_q <= ST_DIVQ_W;
				ST_DIVQ_W: begin
					if (status.div_done) begin
						state_q <= ST_QSTORE;
					end
				end
				ST_QSTORE:  state_q <= ST_MULX;
				ST_MULX:    state_q <= ST_DIVX_LD;
				ST_DIVX_LD: state_q <= ST_DIVX_W;
				ST_DIVX_W: begin
					if (status.div_done) begin
						state_q <= ST_DIRX_ST;
					end
				end
				ST_DIRX_ST: state_q <= ST_MULY;
				ST_MULY:    state_q <= ST_DIVY_LD;
				ST_DIVY_LD: state_q <= ST_DIVY_W;
				ST_DIVY_W: begin
					if (status.div_done) begin
						state_q <= ST_DIRY_ST;
					end
				end
				ST_DIRY_ST:   state_q <= ST_CORD_INIT;
				ST_CORD_INIT: state_q <= ST_CORD;
				ST_CORD: begin
					if (status.cord_last) begin
						state_q <= ST_ANG_ST;
					end
				end
				ST_ANG_ST: begin
					if (side_q) begin
						side_q  <= 1'b0;
						state_q <= ST_TRG_LD;
					end else begin
						side_q  <= 1'b1;
						state_q <= ST_CLAMP;
					end
				end
				ST_TRG_LD: state_q <= ST_TRG_W;
				ST_TRG_W: begin
					if (status.div_done) begin
						state_q <= ST_TRG_ST;
					end
				end
				ST_TRG_ST: begin
					if (side_q) begin
						side_q  <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						side_q  <= 1'b1;
						state_q <= ST_TRG_LD;
					end
				end
				ST_OUT: begin
					if (publish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

	publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == gic_pkg::OP_PUBLISH |-> (!out_valid_q || !out_stall))
		else $error("result published over one still waiting");

	valid_from_publish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result valid raised outside the output state");

	load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == gic_pkg::OP_LOAD |=> state_q == ST_ROUTE)
		else $error("sample load did not start a conditioning pass");

endmodule

@@ hw/rtl/gamepad_input_conditioner.sv @@
`timescale 1ns / 1ps
// With the pad present, a sample runs through the 31-step square root of each stick,
// the shared 48-step divider (up to eight divisions per sample) and the 20-step CORDIC
// of each stick outside the deadzone.
// Throughput: one sample per pass; the next request is taken once the result is
// in the output register. Reset clears the sequencer, the output valid and the
// held button mask, and loads the deadzone and mode registers with their defaults.
// ----------------------------------------------------------------------------
// gamepad_input_conditioner
// Scaled radial deadzone for two sticks, linear deadzone for two triggers and
// button edge detection, with an APB-style register port.
// ----------------------------------------------------------------------------
module gamepad_input_conditioner (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] left_x_raw,
	input  logic signed [15:0] left_y_raw,
	input  logic signed [15:0] right_x_raw,
	input  logic signed [15:0] right_y_raw,
	input  logic [14:0]        left_trigger_raw,
	input  logic [14:0]        right_trigger_raw,
	input  logic [14:0]        button_mask,
	input  logic               pad_present,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] left_dir_x,
	output logic signed [15:0] left_dir_y,
	output logic [15:0]        left_magnitude,
	output logic signed [15:0] left_angle,
	output logic signed [15:0] right_dir_x,
	output logic signed [15:0] right_dir_y,
	output logic [15:0]        right_magnitude,
	output logic signed [15:0] right_angle,
	output logic [15:0]        left_trigger_level,
	output logic [15:0]        right_trigger_level,
	output logic [14:0]        pressed_edges,
	output logic [14:0]        released_edges
);

	logic [14:0]          stick_dz_q;
	logic [14:0]          trigger_dz_q;
	logic                 mode_q;
	logic                 wr_en;
	gic_pkg::gic_cmd_t    cmd;
	gic_pkg::gic_status_t status;

	// Register writes complete in the access phase.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stick_dz_q   <= gic_pkg::STICK_DZ_RESET;
			trigger_dz_q <= gic_pkg::TRIGGER_DZ_RESET;
			mode_q       <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				gic_pkg::REG_STICK_DZ:   stick_dz_q   <= pwdata[14:0];
				gic_pkg::REG_TRIGGER_DZ: trigger_dz_q <= pwdata[14:0];
				gic_pkg::REG_SOURCE:     mode_q       <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (paddr[3:2])
			gic_pkg::REG_STICK_DZ:   prdata = {17'd0, stick_dz_q};
			gic_pkg::REG_TRIGGER_DZ: prdata = {17'd0, trigger_dz_q};
			gic_pkg::REG_SOURCE:     prdata = {31'd0, mode_q};
			default:                 prdata = 32'd0;
		endcase
	end

	gic_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	gic_datapath u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.stick_dz            (stick_dz_q),
		.trigger_dz          (trigger_dz_q),
		.mode                (mode_q),
		.left_x_raw          (left_x_raw),
		.left_y_raw          (left_y_raw),
		.right_x_raw         (right_x_raw),
		.right_y_raw         (right_y_raw),
		.left_trigger_raw    (left_trigger_raw),
		.right_trigger_raw   (right_trigger_raw),
		.button_mask         (button_mask),
		.pad_present         (pad_present),
		.left_dir_x          (left_dir_x),
		.left_dir_y          (left_dir_y),
		.left_magnitude      (left_magnitude),
		.left_angle          (left_angle),
		.right_dir_x         (right_dir_x),
		.right_dir_y         (right_dir_y),
		.right_magnitude     (right_magnitude),
		.right_angle         (right_angle),
		.left_trigger_level  (left_trigger_level),
		.right_trigger_level (right_trigger_level),
		.pressed_edges       (pressed_edges),
		.released_edges      (released_edges)
	);

endmodule
